@@ hdl/mlpf_pkg.sv @@
// shared types, constants and helper functions for the perceptron inference block
`timescale 1ns / 1ps
`default_nettype none
package mlpf_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 16;
    localparam int DATA_WIDTH = 16;
    localparam int IDX_W      = $clog2(MAX_WIDTH);
    localparam int LSEL_W     = $clog2(MAX_LAYERS);
    localparam int SIZE_W     = 5;
    localparam int W_DEPTH    = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
    localparam int B_DEPTH    = MAX_LAYERS * MAX_WIDTH;
    localparam int W_AW       = LSEL_W + 2 * IDX_W;
    localparam int B_AW       = LSEL_W + IDX_W;
    localparam int ACC_W      = 40;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 15;

    // opcodes of an input beat
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_INPUT  = 2'd2;

    // activation codes
    localparam logic [1:0] ACT_IDENT   = 2'd0;
    localparam logic [1:0] ACT_CUBE    = 2'd1;
    localparam logic [1:0] ACT_SIGMOID = 2'd2;
    localparam logic [1:0] ACT_LEAKY   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] REG_LAYERS = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SIZE0  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_SIZE1  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SIZE2  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SIZE3  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ACT    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_LIMIT  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_COEF   = 3'd7;

    typedef enum logic [1:0] {
        K_WEIGHT,
        K_BIAS,
        K_INPUT
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [W_AW-1:0]        waddr;
        logic [B_AW-1:0]        baddr;
        logic [DATA_WIDTH-1:0]  data;
        logic                   last;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        layers;
        logic [SIZE_W-1:0] size0;
        logic [SIZE_W-1:0] size1;
        logic [SIZE_W-1:0] size2;
        logic [SIZE_W-1:0] size3;
        logic [7:0]        act;
        logic [14:0]       limit;
        logic [9:0]        coef;
    } cfg_t;

    typedef logic [8:0] sig_tab_t [256];

    // restoring shift-subtract quotient, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid table over [-8,8) at steps of 1/16, built at elaboration
    function automatic sig_tab_t sig_build();
        sig_tab_t    t;
        logic [63:0] pos [129];
        logic [63:0] e;
        logic [63:0] den;
        e = 64'd1 << 32;
        for (int n = 0; n <= 128; n++) begin
            den    = (64'd1 << 32) + e;
            pos[n] = udiv64((64'd1 << 40) + (den >> 1), den);
            e      = (e * 64'd4034748382 + (64'd1 << 31)) >> 32;
        end
        for (int k = 0; k < 256; k++) begin
            if (k >= 128) t[k] = pos[k-128][8:0];
            else          t[k] = 9'd256 - pos[128-k][8:0];
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TABLE = sig_build();

    // symmetric saturation to [-lim, lim]
    function automatic logic [15:0] clamp32(input logic signed [31:0] x,
                                            input logic [14:0] lim);
        logic signed [31:0] l;
        l = signed'({17'd0, lim});
        if (x > l)       return l[15:0];
        else if (x < -l) return 16'(-l);
        else             return x[15:0];
    endfunction

    // size 0 counts as 1, above MAX_WIDTH as MAX_WIDTH
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0)                          return SIZE_W'(1);
        else if (s > SIZE_W'(MAX_WIDTH))      return SIZE_W'(MAX_WIDTH);
        else                                  return s;
    endfunction

endpackage
`default_nettype wire

@@ hdl/mlpf_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module mlpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/mlpf_front.sv @@
// front end: decodes input beats, clamps input elements, two-entry command queue
`timescale 1ns / 1ps
`default_nettype none
module mlpf_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [31:0]         s_tdata,
    input  wire  [1:0]          s_tuser,
    input  wire                 s_tlast,
    input  wire  [14:0]         limit,
    output logic                cmd_valid,
    output mlpf_pkg::cmd_t      cmd,
    input  wire                 cmd_pop
);
    import mlpf_pkg::*;

    cmd_t        q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        dec;
    logic        keep;
    logic        push;
    logic [LSEL_W-1:0] sel;
    logic [IDX_W-1:0]  src, dst;
    logic [DATA_WIDTH-1:0] data;

    assign sel  = s_tdata[1:0];
    assign src  = s_tdata[5:2];
    assign dst  = s_tdata[9:6];
    assign data = s_tdata[25:10];

    always_comb begin
        dec       = '0;
        keep      = 1'b0;
        dec.last  = s_tlast;
        dec.waddr = {sel, src, dst};
        dec.baddr = {sel, dst};
        dec.data  = data;
        unique case (s_tuser)
            OP_WEIGHT: begin
                dec.kind = K_WEIGHT;
                keep     = (32'(sel) < MAX_LAYERS - 1);
            end
            OP_BIAS: begin
                dec.kind = K_BIAS;
                keep     = 1'b1;
            end
            OP_INPUT: begin
                dec.kind = K_INPUT;
                dec.data = clamp32(32'(signed'(data)), limit);
                keep     = 1'b1;
            end
            default: begin
                dec.kind = K_INPUT;
                keep     = 1'b0;
            end
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end
endmodule
`default_nettype wire

@@ hdl/mlpf_engine.sv @@
// back end: stores, multiply-accumulate sequencer, activations and result register
`timescale 1ns / 1ps
`default_nettype none
module mlpf_engine (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  mlpf_pkg::cfg_t      cfg,
    input  wire                 cmd_valid,
    input  mlpf_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [23:0]         m_tdata,
    output logic [0:0]          m_tuser,
    output logic                m_tlast
);
    import mlpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_MAC, S_DRAIN, S_BIAS, S_SCALE,
        S_ACT1, S_ACT2, S_ACT3, S_EMIT
    } state_t;

    state_t state_reg;
    logic [SIZE_W-1:0]  cnt_reg;
    logic [LSEL_W-1:0]  layer_reg;
    logic [IDX_W-1:0]   j_reg, l_reg;
    logic               cur_reg;
    logic [DATA_WIDTH-1:0] act_reg [2][MAX_WIDTH];
    logic signed [DATA_WIDTH-1:0] a1_reg;
    logic               v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0] x_reg;
    logic signed [31:0] sq_reg;
    logic signed [31:0] r_reg;
    logic [15:0]        oval_reg;
    logic [IDX_W-1:0]   oidx_reg;
    logic               olast_reg, ostat_reg, ovalid_reg;

    logic [15:0] w_rdata, b_rdata;
    logic        w_we, b_we;
    logic [W_AW-1:0] w_raddr;
    logic [B_AW-1:0] b_raddr;

    logic [SIZE_W-1:0] sz [MAX_LAYERS];
    logic [2:0]        layers;
    logic [SIZE_W-1:0] ns, nd, nout;
    logic [LSEL_W-1:0] lp1;
    logic [1:0]        code;
    logic              out_free;
    logic              emit_fire;
    logic [SIZE_W-1:0] cnt_inc;
    logic signed [47:0] cube;
    logic signed [25:0] lprod;
    logic signed [26:0] lneg;
    logic [11:0]        sidx;

    assign sz[0] = eff_size(cfg.size0);
    assign sz[1] = eff_size(cfg.size1);
    assign sz[2] = eff_size(cfg.size2);
    assign sz[3] = eff_size(cfg.size3);
    assign layers = (cfg.layers < 3'd2) ? 3'd2 :
                    (cfg.layers > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : cfg.layers;
    assign lp1  = layer_reg + 1'b1;
    assign ns   = sz[layer_reg];
    assign nd   = sz[lp1];
    assign nout = sz[2'(layers - 3'd1)];
    assign code = 2'(cfg.act >> {lp1, 1'b0});
    assign out_free  = !ovalid_reg || m_tready;
    assign emit_fire = out_free && (state_reg == S_ERR || state_reg == S_EMIT);
    assign cnt_inc   = (cnt_reg < 5'd31) ? cnt_reg + 5'd1 : cnt_reg;

    assign w_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == K_WEIGHT);
    assign b_we    = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == K_BIAS);
    assign w_raddr = {layer_reg, j_reg, l_reg};
    assign b_raddr = {lp1, l_reg};

    mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(W_DEPTH)) u_wram (
        .aclk(aclk), .we(w_we), .waddr(cmd.waddr), .wdata(cmd.data),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    mlpf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(B_DEPTH)) u_bram (
        .aclk(aclk), .we(b_we), .waddr(cmd.baddr), .wdata(cmd.data),
        .raddr(b_raddr), .rdata(b_rdata)
    );

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'd0, oidx_reg, oval_reg};
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    assign cube  = sq_reg * x_reg;
    assign lprod = signed'(cfg.coef) * x_reg;
    assign lneg  = -27'(lprod);
    assign sidx  = 12'(x_reg + 16'sd2048);

    // multiply-accumulate pipe: read issue, product, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == S_MAC);
            v2_reg <= v1_reg;
        end
        a1_reg   <= act_reg[cur_reg][j_reg];
        prod_reg <= a1_reg * signed'(w_rdata);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            layer_reg  <= '0;
            j_reg      <= '0;
            l_reg      <= '0;
            cur_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            acc_reg    <= '0;
        end else begin
            ovalid_reg <= emit_fire || (ovalid_reg && !m_tready);
            if (v2_reg) acc_reg <= acc_reg + ACC_W'(prod_reg);
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd.kind == K_INPUT) begin
                        if (cnt_reg < SIZE_W'(MAX_WIDTH))
                            act_reg[0][cnt_reg[IDX_W-1:0]] <= cmd.data;
                        if (cmd.last) begin
                            cnt_reg   <= '0;
                            layer_reg <= '0;
                            j_reg     <= '0;
                            l_reg     <= '0;
                            cur_reg   <= 1'b0;
                            acc_reg   <= '0;
                            state_reg <= (cnt_inc == sz[0]) ? S_MAC : S_ERR;
                        end else begin
                            cnt_reg <= cnt_inc;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        oval_reg   <= '0;
                        oidx_reg   <= '0;
                        olast_reg  <= 1'b1;
                        ostat_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_MAC: begin
                    j_reg <= j_reg + 1'b1;
                    if ({1'b0, j_reg} == ns - 5'd1) state_reg <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!v1_reg && !v2_reg) state_reg <= S_BIAS;
                end
                S_BIAS: begin
                    acc_reg   <= acc_reg + (ACC_W'(signed'(b_rdata)) <<< 8);
                    state_reg <= S_SCALE;
                end
                S_SCALE: begin
                    x_reg     <= clamp32(32'(acc_reg >>> 8), cfg.limit);
                    state_reg <= S_ACT1;
                end
                S_ACT1: begin
                    sq_reg    <= x_reg * x_reg;
                    state_reg <= S_ACT2;
                end
                S_ACT2: begin
                    unique case (code)
                        ACT_CUBE: r_reg <= 32'(cube >>> 16);
                        ACT_SIGMOID: begin
                            if (x_reg < -16'sd2048)     r_reg <= '0;
                            else if (x_reg >= 16'sd2048) r_reg <= 32'sd256;
                            else r_reg <= 32'(SIG_TABLE[sidx[11:4]]);
                        end
                        ACT_LEAKY: begin
                            if (x_reg < 0) r_reg <= 32'(lneg >>> 8);
                            else           r_reg <= 32'(x_reg);
                        end
                        default: r_reg <= 32'(x_reg);
                    endcase
                    state_reg <= S_ACT3;
                end
                S_ACT3: begin
                    act_reg[!cur_reg][l_reg] <= clamp32(r_reg, cfg.limit);
                    acc_reg <= '0;
                    j_reg   <= '0;
                    if ({1'b0, l_reg} == nd - 5'd1) begin
                        l_reg     <= '0;
                        cur_reg   <= !cur_reg;
                        layer_reg <= lp1;
                        state_reg <= (3'(lp1) + 3'd1 == layers) ? S_EMIT : S_MAC;
                    end else begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_MAC;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        oval_reg   <= act_reg[cur_reg][l_reg];
                        oidx_reg   <= l_reg;
                        olast_reg  <= ({1'b0, l_reg} == nout - 5'd1);
                        ostat_reg  <= 1'b0;
                        l_reg      <= l_reg + 1'b1;
                        if ({1'b0, l_reg} == nout - 5'd1) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/mlp_forward_inference.sv @@
// top level: q8.8 multilayer perceptron forward pass with config registers
// usage:
//  input stream s_*: tuser carries the opcode (write weight, write bias, input
//  element), tdata the layer select, source, destination and value, tlast
//  marks the last element of a vector. weight and bias beats fill the stores;
//  input beats are clamped and collected, the beat with tlast starts the pass.
//  result stream m_*: one beat per output neuron, tlast on the final one,
//  tuser set on the single beat sent when the input count is wrong.
//  flow: a store or input beat is taken through a two-entry command queue.
//  a pass works through each layer pair neuron by neuron: one
//  multiply-accumulate per cycle on the weight ram read port, a drain of the
//  product pipe, then bias, scaling and the activation states; the output
//  beats follow the last layer.
//  while a pass runs the queue fills and then s_tready falls.
//  a stalled receiver holds the result register; the sequencer waits on it.
//  reset (aresetn low, synchronous) empties the queue, clears the count and
//  loads the register defaults; weight and bias rams keep no reset value.
//  the user must write configuration only while idle; the block does no check.
`timescale 1ns / 1ps
`default_nettype none
module mlp_forward_inference (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_addr,
    input  wire  [14:0] cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // layer_sel, src_index, dst_index, data_value
    input  wire  [1:0]  s_tuser,   // opcode
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // out_value, out_index
    output logic [0:0]  m_tuser,   // status
    output logic        m_tlast
);
    import mlpf_pkg::*;

    cfg_t cfg_reg;
    logic cmd_valid, cmd_pop;
    cmd_t cmd;

    // register file, defaults from the reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.layers <= 3'd4;
            cfg_reg.size0  <= 5'd16;
            cfg_reg.size1  <= 5'd16;
            cfg_reg.size2  <= 5'd16;
            cfg_reg.size3  <= 5'd16;
            cfg_reg.act    <= 8'd0;
            cfg_reg.limit  <= 15'd32767;
            cfg_reg.coef   <= 10'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_LAYERS: cfg_reg.layers <= cfg_wdata[2:0];
                REG_SIZE0:  cfg_reg.size0  <= cfg_wdata[4:0];
                REG_SIZE1:  cfg_reg.size1  <= cfg_wdata[4:0];
                REG_SIZE2:  cfg_reg.size2  <= cfg_wdata[4:0];
                REG_SIZE3:  cfg_reg.size3  <= cfg_wdata[4:0];
                REG_ACT:    cfg_reg.act    <= cfg_wdata[7:0];
                REG_LIMIT:  cfg_reg.limit  <= cfg_wdata[14:0];
                REG_COEF:   cfg_reg.coef   <= cfg_wdata[9:0];
                default:    cfg_reg.coef   <= cfg_reg.coef;
            endcase
        end
    end

    // decode and queue
    mlpf_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast), .limit(cfg_reg.limit),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
    );

    // stores, sequencer and result register
    mlpf_engine u_engine (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );
endmodule
`default_nettype wire
